/* rtl/dsfp_pkg.sv */
// Shared types and constants for the decimal string to fixed-point converter.
// Holds payload structs, parse phase and controller state types, and the control interface.
package dsfp_pkg;

    // payload widths
    localparam int CHAR_W = 8;
    localparam int AMT_W  = 61;
    localparam int STS_W  = 3;

    // configuration
    localparam int DEC_W       = 5;
    localparam int LIM_W       = 60;
    localparam int CFG_DW      = 64;
    localparam int ADDR_W      = 4;
    localparam int REG_IDX_BIT = 3;
    localparam logic REG_DECIMALS = 1'b0;
    localparam logic REG_LIMIT    = 1'b1;

    localparam int RADIX = 10;
    localparam int REM_W = $clog2(RADIX);
    localparam logic [DEC_W-1:0] DECIMALS_RESET    = DEC_W'(8);
    localparam logic [LIM_W-1:0] LIMIT_RESET       = 60'd999999999999999999;
    localparam logic [LIM_W-1:0] LIMIT_DIV10_RESET = LIMIT_RESET / RADIX;

    // length counters flag an overflow error at this many digits
    localparam longint MAX_LENGTH = 65535;
    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH);

    // internal value widths
    localparam int MANT_W = 61;
    localparam int EXP_W  = 61;
    localparam int T_W    = LEN_W + 2;
    localparam int E_W    = EXP_W + 2;
    localparam int SCALE_LIMIT = 18;
    localparam int SCL_W  = $clog2(SCALE_LIMIT);

    // characters
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOWER_E = 8'h65;
    localparam logic [CHAR_W-1:0] CH_UPPER_E = 8'h45;
    localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;

    // result status codes
    localparam logic [STS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STS_W-1:0] ST_OVERFLOW = 3'd1;
    localparam logic [STS_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [STS_W-1:0] ST_GARBAGE  = 3'd3;
    localparam logic [STS_W-1:0] ST_SMALL    = 3'd4;
    localparam logic [STS_W-1:0] ST_LARGE    = 3'd5;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic signed [AMT_W-1:0] amount;
        logic [STS_W-1:0]        status;
    } out_item_t;

    typedef enum logic [3:0] {
        PH_START,
        PH_MINUS,
        PH_LEAD_ZERO,
        PH_INT,
        PH_POINT,
        PH_FRAC,
        PH_EXP_MARK,
        PH_EXP_SIGN,
        PH_EXP,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DECODE,
        C_MUL,
        C_END_SUM,
        C_END_EXP,
        C_FIN,
        C_PUSH
    } ctrl_state_t;

    // steps of the shift-add divide by ten
    typedef enum logic [2:0] {
        DV_IDLE,
        DV_FOLD4,
        DV_FOLD8,
        DV_FOLD16,
        DV_FOLD32,
        DV_SHIFT,
        DV_REM,
        DV_FIX
    } div_step_t;

    typedef struct packed {
        logic load_in;
        logic decode;
        logic mul_step;
        logic end_sum;
        logic end_exp;
        logic fin_step;
        logic push;
    } dp_cmd_t;

    typedef struct packed {
        logic action;
        logic need_mul;
        logic mul_end;
        logic finishable;
        logic fin_end;
    } dp_status_t;

    function automatic logic [MANT_W-1:0] times10(input logic [MANT_W-1:0] x);
        return (x << 3) + (x << 1);
    endfunction

endpackage

/* rtl/dsfp_div10.sv */
// Magnitude limit divided by ten through a shift-add reciprocal, one step per cycle; a new start restarts it.
// Depends on dsfp_pkg.
module dsfp_div10 (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [dsfp_pkg::LIM_W-1:0] dividend,
    output logic                       busy,
    output logic [dsfp_pkg::LIM_W-1:0] quotient
);
    import dsfp_pkg::*;

    div_step_t        step_reg, step_next;
    logic [LIM_W-1:0] num_reg, num_next;
    logic [LIM_W-1:0] quo_reg, quo_next;
    logic [REM_W:0]   rem_reg, rem_next;
    logic [LIM_W-1:0] quo_x10, rem_full;

    assign quo_x10  = (quo_reg << 3) + (quo_reg << 1);
    assign rem_full = num_reg - quo_x10;

    always_comb begin
        step_next = step_reg;
        if (start) begin
            step_next = DV_FOLD4;
        end else begin
            case (step_reg)
                DV_FOLD4:  step_next = DV_FOLD8;
                DV_FOLD8:  step_next = DV_FOLD16;
                DV_FOLD16: step_next = DV_FOLD32;
                DV_FOLD32: step_next = DV_SHIFT;
                DV_SHIFT:  step_next = DV_REM;
                DV_REM:    step_next = DV_FIX;
                default:   step_next = DV_IDLE;
            endcase
        end
    end

    always_comb begin
        num_next = num_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start) begin
            // 0.75 * n, refined below toward 0.8 * n; the estimate falls short by at most one
            num_next = dividend;
            quo_next = (dividend >> 1) + (dividend >> 2);
        end else begin
            case (step_reg)
                DV_FOLD4:  quo_next = quo_reg + (quo_reg >> 4);
                DV_FOLD8:  quo_next = quo_reg + (quo_reg >> 8);
                DV_FOLD16: quo_next = quo_reg + (quo_reg >> 16);
                DV_FOLD32: quo_next = quo_reg + (quo_reg >> 32);
                DV_SHIFT:  quo_next = quo_reg >> 3;
                DV_REM:    rem_next = rem_full[REM_W:0];
                DV_FIX: begin
                    if (rem_reg > (REM_W + 1)'(RADIX - 1)) quo_next = quo_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= DV_IDLE;
            num_reg  <= LIMIT_RESET;
            quo_reg  <= LIMIT_DIV10_RESET;
            rem_reg  <= '0;
        end else begin
            step_reg <= step_next;
            num_reg  <= num_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy     = step_reg != DV_IDLE;
    assign quotient = quo_reg;

endmodule

/* rtl/dsfp_datapath.sv */
// Datapath: parse state, mantissa and exponent registers, scaling by ten, result register.
// Depends on dsfp_pkg; driven by dsfp_ctrl through dp_cmd_t.
module dsfp_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dsfp_pkg::dp_cmd_t          cmd,
    input  dsfp_pkg::in_item_t         s_data,
    input  logic [dsfp_pkg::DEC_W-1:0] decimals,
    input  logic [dsfp_pkg::LIM_W-1:0] limit,
    input  logic [dsfp_pkg::LIM_W-1:0] limit_div10,
    output dsfp_pkg::dp_status_t       status,
    output dsfp_pkg::out_item_t        m_data
);
    import dsfp_pkg::*;

    in_item_t          in_reg, in_next;
    phase_t            phase_reg, phase_next;
    logic [MANT_W-1:0] mant_reg, mant_next;
    logic              neg_reg, neg_next;
    logic [LEN_W-1:0]  pz_reg, pz_next;
    logic [LEN_W-1:0]  frac_reg, frac_next;
    logic [EXP_W-1:0]  expv_reg, expv_next;
    logic              expneg_reg, expneg_next;
    logic [STS_W-1:0]  err_reg, err_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [T_W-1:0]    t_reg, t_next;
    logic              exp_ok_reg, exp_ok_next;
    logic [AMT_W-1:0]  res_amount_reg, res_amount_next;
    logic [STS_W-1:0]  res_status_reg, res_status_next;
    out_item_t         out_reg, out_next;

    logic              is_digit, is_nz, is_e;
    logic [MANT_W-1:0] digit_val, lim_ext, lim10_ext, mant_x10;
    logic [EXP_W-1:0]  exp_x10;
    logic              mant_gt_l10, mant_gt_lim, exp_gt_l10;
    logic              frac_phase, need_mul;
    logic [E_W-1:0]    exp_ext, e_val;
    logic              e_neg, e_large;

    assign is_digit   = (in_reg.char_code >= CH_ZERO) && (in_reg.char_code <= CH_NINE);
    assign is_nz      = is_digit && (in_reg.char_code != CH_ZERO);
    assign is_e       = (in_reg.char_code == CH_LOWER_E) || (in_reg.char_code == CH_UPPER_E);
    assign digit_val  = MANT_W'(in_reg.char_code[3:0]);
    assign lim_ext    = MANT_W'(limit);
    assign lim10_ext  = MANT_W'(limit_div10);
    assign mant_x10   = times10(mant_reg);
    assign exp_x10    = EXP_W'(times10(MANT_W'(expv_reg)));
    assign mant_gt_l10 = mant_reg > lim10_ext;
    assign mant_gt_lim = mant_reg > lim_ext;
    assign exp_gt_l10  = MANT_W'(expv_reg) > lim10_ext;
    assign frac_phase = (phase_reg == PH_POINT) || (phase_reg == PH_FRAC);
    // nonzero digit into a nonzero mantissa: pending zeros get multiplied in first
    assign need_mul   = ((phase_reg == PH_INT) || frac_phase) && is_nz && (mant_reg != '0);

    // final power of ten: +-exponent - fraction digits + pending zeros + decimals
    assign exp_ext = E_W'(expv_reg);
    assign e_val   = (expneg_reg ? (E_W'(0) - exp_ext) : exp_ext)
                   + {{(E_W - T_W){t_reg[T_W-1]}}, t_reg};
    assign e_neg   = e_val[E_W-1];
    assign e_large = !e_neg && (e_val[E_W-2:0] >= (E_W - 1)'(SCALE_LIMIT));

    always_comb begin
        in_next         = in_reg;
        phase_next      = phase_reg;
        mant_next       = mant_reg;
        neg_next        = neg_reg;
        pz_next         = pz_reg;
        frac_next       = frac_reg;
        expv_next       = expv_reg;
        expneg_next     = expneg_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        t_next          = t_reg;
        exp_ok_next     = exp_ok_reg;
        res_amount_next = res_amount_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;

        if (cmd.load_in) begin
            in_next = s_data;
        end

        if (cmd.decode) begin
            if (in_reg.action) begin
                res_amount_next = '0;
                exp_ok_next     = 1'b0;
                res_status_next = (phase_reg == PH_ERROR) ? err_reg : ST_MISSING;
            end else if (need_mul) begin
                cnt_next = pz_reg;
            end else begin
                case (phase_reg)
                    PH_START, PH_MINUS: begin
                        if (phase_reg == PH_START && in_reg.char_code == CH_MINUS) begin
                            neg_next   = 1'b1;
                            phase_next = PH_MINUS;
                        end else if (in_reg.char_code == CH_ZERO) begin
                            phase_next = PH_LEAD_ZERO;
                        end else if (is_digit) begin
                            mant_next  = digit_val;
                            pz_next    = '0;
                            phase_next = PH_INT;
                        end else begin
                            phase_next = PH_ERROR;
                            err_next   = ST_MISSING;
                        end
                    end
                    PH_LEAD_ZERO, PH_INT: begin
                        if (phase_reg == PH_INT && is_digit) begin
                            if (is_nz) begin
                                mant_next = mant_reg + digit_val;
                                pz_next   = '0;
                            end else if (pz_reg >= LEN_MAX) begin
                                phase_next = PH_ERROR;
                                err_next   = ST_OVERFLOW;
                            end else begin
                                pz_next = pz_reg + 1'b1;
                            end
                        end else if (in_reg.char_code == CH_POINT) begin
                            phase_next = PH_POINT;
                        end else if (is_e) begin
                            phase_next = PH_EXP_MARK;
                        end else begin
                            phase_next = PH_ERROR;
                            err_next   = ST_GARBAGE;
                        end
                    end
                    PH_POINT, PH_FRAC: begin
                        if (is_digit) begin
                            if (is_nz) begin
                                // mantissa is zero here, so the digit just lands
                                mant_next = mant_reg + digit_val;
                                pz_next   = '0;
                                if (frac_reg >= LEN_MAX) begin
                                    phase_next = PH_ERROR;
                                    err_next   = ST_OVERFLOW;
                                end else begin
                                    frac_next  = frac_reg + 1'b1;
                                    phase_next = PH_FRAC;
                                end
                            end else if (pz_reg >= LEN_MAX || frac_reg >= LEN_MAX) begin
                                phase_next = PH_ERROR;
                                err_next   = ST_OVERFLOW;
                            end else begin
                                pz_next    = pz_reg + 1'b1;
                                frac_next  = frac_reg + 1'b1;
                                phase_next = PH_FRAC;
                            end
                        end else if (phase_reg == PH_POINT) begin
                            phase_next = PH_ERROR;
                            err_next   = ST_MISSING;
                        end else if (is_e) begin
                            phase_next = PH_EXP_MARK;
                        end else begin
                            phase_next = PH_ERROR;
                            err_next   = ST_GARBAGE;
                        end
                    end
                    PH_EXP_MARK, PH_EXP_SIGN, PH_EXP: begin
                        if (is_digit) begin
                            if (exp_gt_l10) begin
                                phase_next = PH_ERROR;
                                err_next   = ST_OVERFLOW;
                            end else begin
                                expv_next  = exp_x10 + EXP_W'(in_reg.char_code[3:0]);
                                phase_next = PH_EXP;
                            end
                        end else if (phase_reg == PH_EXP_MARK && in_reg.char_code == CH_PLUS) begin
                            phase_next = PH_EXP_SIGN;
                        end else if (phase_reg == PH_EXP_MARK && in_reg.char_code == CH_MINUS) begin
                            expneg_next = 1'b1;
                            phase_next  = PH_EXP_SIGN;
                        end else if (phase_reg == PH_EXP) begin
                            phase_next = PH_ERROR;
                            err_next   = ST_GARBAGE;
                        end else begin
                            phase_next = PH_ERROR;
                            err_next   = ST_MISSING;
                        end
                    end
                    default: begin
                        // error latched: ignore until the end of string
                    end
                endcase
            end
        end

        if (cmd.mul_step) begin
            if (mant_gt_l10) begin
                phase_next = PH_ERROR;
                err_next   = ST_OVERFLOW;
            end else if (cnt_reg == '0) begin
                mant_next = mant_x10 + digit_val;
                pz_next   = '0;
                if (frac_phase) begin
                    if (frac_reg >= LEN_MAX) begin
                        phase_next = PH_ERROR;
                        err_next   = ST_OVERFLOW;
                    end else begin
                        frac_next  = frac_reg + 1'b1;
                        phase_next = PH_FRAC;
                    end
                end
            end else begin
                mant_next = mant_x10;
                cnt_next  = cnt_reg - 1'b1;
            end
        end

        if (cmd.end_sum) begin
            t_next = T_W'(pz_reg) + T_W'(decimals) - T_W'(frac_reg);
        end

        if (cmd.end_exp) begin
            cnt_next = LEN_W'(e_val[SCL_W-1:0]);
            if (e_neg) begin
                res_status_next = ST_SMALL;
                exp_ok_next     = 1'b0;
            end else if (e_large) begin
                res_status_next = ST_LARGE;
                exp_ok_next     = 1'b0;
            end else begin
                res_status_next = ST_OK;
                exp_ok_next     = 1'b1;
            end
        end

        if (cmd.fin_step && exp_ok_reg) begin
            if (cnt_reg == '0) begin
                if (mant_gt_lim) begin
                    res_status_next = ST_OVERFLOW;
                end else begin
                    res_amount_next = neg_reg ? (MANT_W'(0) - mant_reg) : mant_reg;
                end
            end else if (mant_gt_l10) begin
                res_status_next = ST_OVERFLOW;
            end else begin
                mant_next = mant_x10;
                cnt_next  = cnt_reg - 1'b1;
            end
        end

        if (cmd.push) begin
            out_next.amount = res_amount_reg;
            out_next.status = res_status_reg;
            phase_next      = PH_START;
            mant_next       = '0;
            neg_next        = 1'b0;
            pz_next         = '0;
            frac_next       = '0;
            expv_next       = '0;
            expneg_next     = 1'b0;
            err_next        = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            mant_reg   <= '0;
            neg_reg    <= 1'b0;
            pz_reg     <= '0;
            frac_reg   <= '0;
            expv_reg   <= '0;
            expneg_reg <= 1'b0;
            err_reg    <= ST_OK;
            exp_ok_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            mant_reg   <= mant_next;
            neg_reg    <= neg_next;
            pz_reg     <= pz_next;
            frac_reg   <= frac_next;
            expv_reg   <= expv_next;
            expneg_reg <= expneg_next;
            err_reg    <= err_next;
            exp_ok_reg <= exp_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg         <= in_next;
        cnt_reg        <= cnt_next;
        t_reg          <= t_next;
        res_amount_reg <= res_amount_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

    assign status.action     = in_reg.action;
    assign status.need_mul   = need_mul;
    assign status.mul_end    = mant_gt_l10 || (cnt_reg == '0);
    assign status.finishable = (phase_reg == PH_LEAD_ZERO) || (phase_reg == PH_INT)
                             || (phase_reg == PH_FRAC) || (phase_reg == PH_EXP);
    assign status.fin_end    = !exp_ok_reg || (cnt_reg == '0) || mant_gt_l10;
    assign m_data            = out_reg;

endmodule

/* rtl/dsfp_ctrl.sv */
// Controller state machine: sequences decode, digit scaling and end-of-string finish.
// Depends on dsfp_pkg; owns the input ready and the output valid.
module dsfp_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  logic                    div_busy,
    input  dsfp_pkg::dp_status_t    status,
    output dsfp_pkg::dp_cmd_t       cmd
);
    import dsfp_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE: begin
                if (s_valid && !div_busy) state_next = C_DECODE;
            end
            C_DECODE: begin
                if (status.action) begin
                    state_next = status.finishable ? C_END_SUM : C_PUSH;
                end else begin
                    state_next = status.need_mul ? C_MUL : C_IDLE;
                end
            end
            C_MUL: begin
                if (status.mul_end) state_next = C_IDLE;
            end
            C_END_SUM: state_next = C_END_EXP;
            C_END_EXP: state_next = C_FIN;
            C_FIN: begin
                if (status.fin_end) state_next = C_PUSH;
            end
            C_PUSH: begin
                if (out_free) state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            C_IDLE: begin
                s_ready     = !div_busy;
                cmd.load_in = s_valid && !div_busy;
            end
            C_DECODE:  cmd.decode   = 1'b1;
            C_MUL:     cmd.mul_step = 1'b1;
            C_END_SUM: cmd.end_sum  = 1'b1;
            C_END_EXP: cmd.end_exp  = 1'b1;
            C_FIN:     cmd.fin_step = 1'b1;
            C_PUSH:    cmd.push     = out_free;
            default: begin
            end
        endcase
    end

    // result register stays full until the downstream transfer
    assign m_valid_next = cmd.push ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= C_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/decimal_string_to_fixed_point_top.sv */
// Top level: decimal string to fixed-point converter with config registers.
// Depends on dsfp_pkg, dsfp_div10, dsfp_datapath and dsfp_ctrl.
//
// channel   direction  handshake        payload
// s_        in         s_valid/s_ready  in_item_t  {action, char_code}
// m_        out        m_valid/m_ready  out_item_t {amount, status}
// apb       in/out     psel/penable     decimals at 0x0, magnitude_limit at 0x8
//
// a character is captured, then decoded; a nonzero digit into a nonzero mantissa
// then takes one x10 step per pending zero plus one, through the shared x10 unit,
// cut short at the first overflow
// end item: end_sum, end_exp, x10 per unit of e (final power of ten 0..17), push; no number: push
// writing magnitude_limit starts a divide by ten in dsfp_div10; no input transfer meanwhile
// reset is synchronous and needs no clearing pass; a stalled result holds in its register
module decimal_string_to_fixed_point_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  dsfp_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output dsfp_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsfp_pkg::ADDR_W-1:0] paddr,
    input  logic [dsfp_pkg::CFG_DW-1:0] pwdata,
    output logic [dsfp_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import dsfp_pkg::*;

    logic [DEC_W-1:0] decimals_reg, decimals_next;
    logic [LIM_W-1:0] limit_reg, limit_next;
    logic [LIM_W-1:0] limit_div10;
    logic             cfg_wr, limit_wr, div_busy;
    dp_cmd_t          cmd;
    dp_status_t       dp_status;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign limit_wr = cfg_wr && (paddr[REG_IDX_BIT] == REG_LIMIT);

    always_comb begin
        decimals_next = decimals_reg;
        limit_next    = limit_reg;
        if (cfg_wr) begin
            if (paddr[REG_IDX_BIT] == REG_DECIMALS) decimals_next = pwdata[DEC_W-1:0];
            else limit_next = pwdata[LIM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decimals_reg <= DECIMALS_RESET;
            limit_reg    <= LIMIT_RESET;
        end else begin
            decimals_reg <= decimals_next;
            limit_reg    <= limit_next;
        end
    end

    assign prdata = (paddr[REG_IDX_BIT] == REG_LIMIT) ? CFG_DW'(limit_reg)
                                                      : CFG_DW'(decimals_reg);

    dsfp_div10 u_div10 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (limit_wr),
        .dividend (pwdata[LIM_W-1:0]),
        .busy     (div_busy),
        .quotient (limit_div10)
    );

    dsfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .div_busy (div_busy),
        .status   (dp_status),
        .cmd      (cmd)
    );

    dsfp_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_data      (s_data),
        .decimals    (decimals_reg),
        .limit       (limit_reg),
        .limit_div10 (limit_div10),
        .status      (dp_status),
        .m_data      (m_data)
    );

    // one item at a time: the engine is busy right after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    a_no_accept_while_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> !s_ready)
        else $error("input ready while limit quotient is stale");

    a_limit_write_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        limit_wr |=> div_busy)
        else $error("limit write did not start the divider");

    a_error_amount_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_OK)) |-> (m_data.amount == '0))
        else $error("nonzero amount with error status");

endmodule
